### rtl/dsf_pkg.sv
// Shared types and constants for the damped spring force pipeline.
// No dependencies; every module of the block imports this package.
`default_nettype none
package dsf_pkg;

   localparam int FIELD_W = 32;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam int DIFF_W = FIELD_W + 1;          // endpoint differences
   localparam int RAD_W = 68;                    // sum of three squares
   localparam int ROOT_W = 35;                   // floor sqrt of RAD_W bits
   localparam int SQRT_STAGES = ROOT_W;          // one root bit per stage
   localparam int QUO_W = 31;                    // |u| <= 2^30
   localparam int DIV_STAGES = QUO_W;            // one quotient bit per stage
   localparam int U_W = QUO_W + 1;               // signed direction, Q2.30
   localparam int SIG_W = 37;                    // scale unit input
   localparam int SC_W = 35;                     // capped scalar, signed
   localparam int SCALE_STAGES = 3;
   localparam int FRAC_SHIFT = 30;

   localparam logic [CSR_IDX_W-1:0] CSR_STIFFNESS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DAMPING     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REST_LENGTH = 2'd2;

   localparam logic [ROOT_W-1:0] LEN_MIN = ROOT_W'(7);
   localparam logic [SC_W-2:0] SCALAR_CAP = 34'h1_FFFF_FFFF;

   typedef struct packed {
      logic signed [FIELD_W-1:0] pos_a_x;
      logic signed [FIELD_W-1:0] pos_a_y;
      logic signed [FIELD_W-1:0] pos_a_z;
      logic signed [FIELD_W-1:0] pos_b_x;
      logic signed [FIELD_W-1:0] pos_b_y;
      logic signed [FIELD_W-1:0] pos_b_z;
      logic signed [FIELD_W-1:0] vel_a_x;
      logic signed [FIELD_W-1:0] vel_a_y;
      logic signed [FIELD_W-1:0] vel_a_z;
      logic signed [FIELD_W-1:0] vel_b_x;
      logic signed [FIELD_W-1:0] vel_b_y;
      logic signed [FIELD_W-1:0] vel_b_z;
   } req_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0] force_x;
      logic signed [FIELD_W-1:0] force_y;
      logic signed [FIELD_W-1:0] force_z;
      logic                      too_close;
   } rsp_type;

endpackage
`default_nettype wire

### rtl/dsf_sqrt.sv
// Pipelined integer square root, one root bit per register stage.
// Depends on dsf_pkg.
`default_nettype none
module dsf_sqrt (
   input  logic                         clock,
   input  logic [dsf_pkg::RAD_W-1:0]    radicand,
   output logic [dsf_pkg::ROOT_W-1:0]   root_out
);
   import dsf_pkg::*;

   localparam int PAD_W = 2 * ROOT_W;
   localparam int REM_W = ROOT_W + 3;

   logic [PAD_W-1:0]  rad_ff  [SQRT_STAGES];
   logic [PAD_W-1:0]  rad_in  [SQRT_STAGES];
   logic [REM_W-1:0]  rem_ff  [SQRT_STAGES];
   logic [REM_W-1:0]  rem_in  [SQRT_STAGES];
   logic [ROOT_W-1:0] root_ff [SQRT_STAGES];
   logic [ROOT_W-1:0] root_in [SQRT_STAGES];

   always_comb begin
      logic [PAD_W-1:0]  rad_prev;
      logic [REM_W-1:0]  rem_prev;
      logic [REM_W-1:0]  rem_sh;
      logic [REM_W-1:0]  trial;
      logic [ROOT_W-1:0] root_prev;
      for (int j = 0; j < SQRT_STAGES; j++) begin
         if (j == 0) begin
            rad_prev  = PAD_W'(radicand);
            rem_prev  = '0;
            root_prev = '0;
         end else begin
            rad_prev  = rad_ff[j-1];
            rem_prev  = rem_ff[j-1];
            root_prev = root_ff[j-1];
         end
         // bring down the next bit pair, try root*4 + 1
         rem_sh = {rem_prev[REM_W-3:0], rad_prev[PAD_W-1 -: 2]};
         trial  = REM_W'({root_prev, 2'b01});
         if (rem_sh >= trial) begin
            rem_in[j]  = rem_sh - trial;
            root_in[j] = {root_prev[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in[j]  = rem_sh;
            root_in[j] = {root_prev[ROOT_W-2:0], 1'b0};
         end
         rad_in[j] = {rad_prev[PAD_W-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign root_out = root_ff[SQRT_STAGES-1];

endmodule
`default_nettype wire

### rtl/dsf_div.sv
// Pipelined restoring divider: (dividend << 30) / divisor, one quotient bit a stage.
// Depends on dsf_pkg. Dividend must not exceed divisor.
`default_nettype none
module dsf_div (
   input  logic                          clock,
   input  logic [dsf_pkg::DIFF_W-1:0]    dividend,
   input  logic [dsf_pkg::ROOT_W-1:0]    divisor,
   output logic [dsf_pkg::QUO_W-1:0]     quotient
);
   import dsf_pkg::*;

   localparam int REM_W = ROOT_W;

   logic [REM_W-1:0]  rem_ff [DIV_STAGES];
   logic [REM_W-1:0]  rem_in [DIV_STAGES];
   logic [ROOT_W-1:0] dvs_ff [DIV_STAGES];
   logic [ROOT_W-1:0] dvs_in [DIV_STAGES];
   logic [QUO_W-1:0]  quo_ff [DIV_STAGES];
   logic [QUO_W-1:0]  quo_in [DIV_STAGES];

   always_comb begin
      logic [REM_W-1:0]  rem_prev;
      logic [ROOT_W-1:0] dvs_prev;
      logic [QUO_W-1:0]  quo_prev;
      logic              next_bit;
      logic [REM_W:0]    rem_sh;
      for (int j = 0; j < DIV_STAGES; j++) begin
         if (j == 0) begin
            // upper dividend bits are known to give zero quotient bits
            rem_prev = REM_W'(dividend >> 1);
            next_bit = dividend[0];
            dvs_prev = divisor;
            quo_prev = '0;
         end else begin
            rem_prev = rem_ff[j-1];
            next_bit = 1'b0;
            dvs_prev = dvs_ff[j-1];
            quo_prev = quo_ff[j-1];
         end
         rem_sh = {rem_prev, next_bit};
         if (rem_sh >= {1'b0, dvs_prev}) begin
            rem_in[j] = REM_W'(rem_sh - {1'b0, dvs_prev});
            quo_in[j] = {quo_prev[QUO_W-2:0], 1'b1};
         end else begin
            rem_in[j] = rem_sh[REM_W-1:0];
            quo_in[j] = {quo_prev[QUO_W-2:0], 1'b0};
         end
         dvs_in[j] = dvs_prev;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff[DIV_STAGES-1];

endmodule
`default_nettype wire

### rtl/dsf_scale.sv
// Signed value times unsigned Q16.16 coefficient, capped at +-SCALAR_CAP.
// Three stages: magnitude, split partial products, combine and cap. Depends on dsf_pkg.
`default_nettype none
module dsf_scale (
   input  logic                               clock,
   input  logic signed [dsf_pkg::SIG_W-1:0]   value,
   input  logic [dsf_pkg::CSR_DATA_W-1:0]     coeff,
   output logic signed [dsf_pkg::SC_W-1:0]    result
);
   import dsf_pkg::*;

   localparam int LO_W = 32;
   localparam int HI_W = SIG_W - LO_W;
   localparam int FULL_W = SIG_W + CSR_DATA_W;
   localparam int SHIFT_W = FULL_W - 16;

   logic                        neg1_ff, neg2_ff;
   logic [SIG_W-1:0]            mag_ff;
   logic [SIG_W-1:0]            mag_in;
   logic [LO_W+CSR_DATA_W-1:0]  lo_ff;
   logic [HI_W+CSR_DATA_W-1:0]  hi_ff;
   logic signed [SC_W-1:0]      result_ff;
   logic signed [SC_W-1:0]      result_in;

   assign mag_in = value[SIG_W-1] ? SIG_W'(-value) : SIG_W'(value);

   always_comb begin
      logic [FULL_W-1:0]  full;
      logic [SHIFT_W-1:0] shifted;
      logic [SC_W-1:0]    capped;
      full    = (FULL_W'(hi_ff) << LO_W) + FULL_W'(lo_ff);
      shifted = full[FULL_W-1:16];
      if (shifted > SHIFT_W'(SCALAR_CAP)) begin
         capped = SC_W'(SCALAR_CAP);
      end else begin
         capped = shifted[SC_W-1:0];
      end
      result_in = neg2_ff ? -$signed(capped) : $signed(capped);
   end

   always_ff @(posedge clock) begin
      neg1_ff   <= value[SIG_W-1];
      mag_ff    <= mag_in;
      neg2_ff   <= neg1_ff;
      lo_ff     <= mag_ff[LO_W-1:0] * coeff;
      hi_ff     <= mag_ff[SIG_W-1:LO_W] * coeff;
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule
`default_nettype wire

### rtl/damped_spring_force.sv
// Top level of the damped spring force pipeline: config registers and datapath.
// Depends on dsf_pkg, dsf_sqrt, dsf_div and dsf_scale.
//
// One spring is accepted every clock cycle (busy stays low). The datapath is 79
// register stages deep and the force is presented on rsp_valid/rsp_data from its
// last register. Results leave in order and the receiver must take them as they
// appear. The depth is set by the square root (35 stages, one root bit each) and
// the direction divider (31 stages, one quotient bit each), plus 13 stages of
// differencing, squaring, multiplies, capping and saturation. stiffness,
// damping_coeff and rest_length must only be written while no spring is in
// flight.
`default_nettype none
module damped_spring_force (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  dsf_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   output dsf_pkg::rsp_type                  rsp_data,
   input  logic                              csr_we,
   input  logic [dsf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [dsf_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import dsf_pkg::*;

   localparam int SQ_W = 2 * DIFF_W;
   localparam int XS_W = ROOT_W + 1;
   localparam int RVU_W = DIFF_W + U_W;
   localparam int W_TERM_W = RVU_W - FRAC_SHIFT;
   localparam int T_W = SC_W + 1;
   localparam int FP_W = SC_W + U_W;
   localparam int FQ_W = FP_W - FRAC_SHIFT;

   typedef struct packed {
      logic                        valid;
      logic [2:0]                  dneg;
      logic [2:0][DIFF_W-1:0]      dmag;
      logic [2:0][DIFF_W-1:0]      rv;
   } root_side_type;

   typedef struct packed {
      logic                        valid;
      logic                        too_close;
      logic [2:0]                  dneg;
      logic [2:0][DIFF_W-1:0]      rv;
      logic [ROOT_W-1:0]           len;
   } dir_side_type;

   typedef struct packed {
      logic                        valid;
      logic                        too_close;
      logic [2:0][U_W-1:0]         u;
   } scale_side_type;

   // configuration
   logic [CSR_DATA_W-1:0] stiffness_ff, damping_ff, rest_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stiffness_ff   <= '0;
         damping_ff     <= '0;
         rest_length_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_STIFFNESS:   stiffness_ff   <= csr_wdata;
            CSR_DAMPING:     damping_ff     <= csr_wdata;
            CSR_REST_LENGTH: rest_length_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   // stage 1: differences
   logic signed [FIELD_W-1:0] pa [3], pb [3], va [3], vb [3];
   assign pa = '{req_data.pos_a_x, req_data.pos_a_y, req_data.pos_a_z};
   assign pb = '{req_data.pos_b_x, req_data.pos_b_y, req_data.pos_b_z};
   assign va = '{req_data.vel_a_x, req_data.vel_a_y, req_data.vel_a_z};
   assign vb = '{req_data.vel_b_x, req_data.vel_b_y, req_data.vel_b_z};

   logic                   v1_ff, v2_ff, v3_ff, v4_ff;
   logic [2:0][DIFF_W-1:0] d1_ff, d1_in, rv1_ff, rv1_in;
   logic [2:0][DIFF_W-1:0] rv2_ff, rv3_ff, rv4_ff;
   logic [2:0][DIFF_W-1:0] dm2_ff, dm2_in, dm3_ff, dm4_ff;
   logic [2:0]             dn2_ff, dn3_ff, dn4_ff;
   logic [2:0][SQ_W-1:0]   sq3_ff, sq3_in;
   logic [RAD_W-1:0]       rad4_ff, rad4_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         d1_in[i]  = DIFF_W'(pb[i]) - DIFF_W'(pa[i]);
         rv1_in[i] = DIFF_W'(vb[i]) - DIFF_W'(va[i]);
         dm2_in[i] = d1_ff[i][DIFF_W-1] ? -d1_ff[i] : d1_ff[i];
         sq3_in[i] = SQ_W'(dm2_ff[i]) * SQ_W'(dm2_ff[i]);
      end
      rad4_in = RAD_W'(sq3_ff[0]) + RAD_W'(sq3_ff[1]) + RAD_W'(sq3_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= start & ~busy;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
      d1_ff   <= d1_in;
      rv1_ff  <= rv1_in;
      for (int i = 0; i < 3; i++) begin
         dn2_ff[i] <= d1_ff[i][DIFF_W-1];
      end
      dm2_ff  <= dm2_in;
      rv2_ff  <= rv1_ff;
      dn3_ff  <= dn2_ff;
      dm3_ff  <= dm2_ff;
      rv3_ff  <= rv2_ff;
      sq3_ff  <= sq3_in;
      dn4_ff  <= dn3_ff;
      dm4_ff  <= dm3_ff;
      rv4_ff  <= rv3_ff;
      rad4_ff <= rad4_in;
   end

   // length
   logic [ROOT_W-1:0] len;
   root_side_type     rs_ff [SQRT_STAGES];
   root_side_type     rs_last;

   dsf_sqrt u_sqrt (
      .clock    (clock),
      .radicand (rad4_ff),
      .root_out (len)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SQRT_STAGES; k++) begin
            rs_ff[k] <= '0;
         end
      end else begin
         rs_ff[0] <= '{valid: v4_ff, dneg: dn4_ff, dmag: dm4_ff, rv: rv4_ff};
         for (int k = 1; k < SQRT_STAGES; k++) begin
            rs_ff[k] <= rs_ff[k-1];
         end
      end
   end

   assign rs_last = rs_ff[SQRT_STAGES-1];

   // direction magnitudes
   logic [2:0][QUO_W-1:0] quo;
   dir_side_type          ds_ff [DIV_STAGES];
   dir_side_type          ds_last;

   for (genvar g = 0; g < 3; g++) begin : g_div
      dsf_div u_div (
         .clock    (clock),
         .dividend (rs_last.dmag[g]),
         .divisor  (len),
         .quotient (quo[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_STAGES; k++) begin
            ds_ff[k] <= '0;
         end
      end else begin
         ds_ff[0] <= '{valid: rs_last.valid, too_close: (len < LEN_MIN),
                       dneg: rs_last.dneg, rv: rs_last.rv, len: len};
         for (int k = 1; k < DIV_STAGES; k++) begin
            ds_ff[k] <= ds_ff[k-1];
         end
      end
   end

   assign ds_last = ds_ff[DIV_STAGES-1];

   // signed direction, stretch, velocity projection
   logic                   vu_ff, vp_ff, vw_ff;
   logic                   tcu_ff, tcp_ff, tcw_ff;
   logic [2:0][U_W-1:0]    uu_ff, uu_in, up_ff, uw_ff;
   logic [2:0][DIFF_W-1:0] rvu_ff;
   logic [XS_W-1:0]        xsu_ff, xsu_in, xsp_ff, xsw_ff;
   logic [2:0][RVU_W-1:0]  prod_ff, prod_in;
   logic [SIG_W-1:0]       w_ff, w_in;

   always_comb begin
      logic [RVU_W-1:0]    biased;
      logic [W_TERM_W-1:0] term;
      for (int i = 0; i < 3; i++) begin
         uu_in[i] = ds_last.dneg[i] ? -U_W'(quo[i]) : U_W'(quo[i]);
         prod_in[i] = RVU_W'($signed(rvu_ff[i]) * $signed(uu_ff[i]));
      end
      xsu_in = XS_W'(ds_last.len) - XS_W'(rest_length_ff);
      // sum of products, each truncated toward zero
      w_in = '0;
      for (int i = 0; i < 3; i++) begin
         biased = prod_ff[i] + (prod_ff[i][RVU_W-1] ?
                  RVU_W'((64'd1 << FRAC_SHIFT) - 64'd1) : RVU_W'(0));
         term   = biased[RVU_W-1:FRAC_SHIFT];
         w_in   = w_in + SIG_W'($signed(term));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vu_ff <= 1'b0;
         vp_ff <= 1'b0;
         vw_ff <= 1'b0;
      end else begin
         vu_ff <= ds_last.valid;
         vp_ff <= vu_ff;
         vw_ff <= vp_ff;
      end
      tcu_ff  <= ds_last.too_close;
      uu_ff   <= uu_in;
      rvu_ff  <= ds_last.rv;
      xsu_ff  <= xsu_in;
      tcp_ff  <= tcu_ff;
      up_ff   <= uu_ff;
      xsp_ff  <= xsu_ff;
      prod_ff <= prod_in;
      tcw_ff  <= tcp_ff;
      uw_ff   <= up_ff;
      xsw_ff  <= xsp_ff;
      w_ff    <= w_in;
   end

   // spring and damping scalars
   logic signed [SC_W-1:0] spring_s, damp_p;
   scale_side_type         ss_ff [SCALE_STAGES];
   scale_side_type         ss_last;

   dsf_scale u_scale_spring (
      .clock  (clock),
      .value  (SIG_W'($signed(xsw_ff))),
      .coeff  (stiffness_ff),
      .result (spring_s)
   );

   dsf_scale u_scale_damp (
      .clock  (clock),
      .value  ($signed(w_ff)),
      .coeff  (damping_ff),
      .result (damp_p)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SCALE_STAGES; k++) begin
            ss_ff[k] <= '0;
         end
      end else begin
         ss_ff[0] <= '{valid: vw_ff, too_close: tcw_ff, u: uw_ff};
         for (int k = 1; k < SCALE_STAGES; k++) begin
            ss_ff[k] <= ss_ff[k-1];
         end
      end
   end

   assign ss_last = ss_ff[SCALE_STAGES-1];

   // total scalar, per-axis force, saturation
   logic                  vt_ff, vf_ff, vo_ff;
   logic                  tct_ff, tcf_ff;
   logic [2:0][U_W-1:0]   ut_ff;
   logic [SC_W-1:0]       t_ff, t_in;
   logic [2:0][FP_W-1:0]  fp_ff, fp_in;
   rsp_type               rsp_ff, rsp_in;

   always_comb begin
      logic signed [T_W-1:0]  tsum;
      logic [FP_W-1:0]        fbiased;
      logic signed [FQ_W-1:0] fq;
      logic signed [FQ_W:0]   fneg;
      logic [2:0][FIELD_W-1:0] fsat;
      tsum = T_W'(spring_s) + T_W'(damp_p);
      if (tsum > $signed(T_W'(SCALAR_CAP))) begin
         t_in = SC_W'(SCALAR_CAP);
      end else if (tsum < -$signed(T_W'(SCALAR_CAP))) begin
         t_in = -SC_W'(SCALAR_CAP);
      end else begin
         t_in = tsum[SC_W-1:0];
      end
      for (int i = 0; i < 3; i++) begin
         fp_in[i] = FP_W'($signed(t_ff) * $signed(ut_ff[i]));
      end
      for (int i = 0; i < 3; i++) begin
         fbiased = fp_ff[i] + (fp_ff[i][FP_W-1] ?
                   FP_W'((64'd1 << FRAC_SHIFT) - 64'd1) : FP_W'(0));
         fq      = $signed(fbiased[FP_W-1:FRAC_SHIFT]);
         fneg    = -(FQ_W + 1)'(fq);
         if (fneg > $signed((FQ_W + 1)'(32'sh7FFF_FFFF))) begin
            fsat[i] = 32'h7FFF_FFFF;
         end else if (fneg < $signed((FQ_W + 1)'(-33'sh8000_0000))) begin
            fsat[i] = 32'h8000_0000;
         end else begin
            fsat[i] = fneg[FIELD_W-1:0];
         end
         if (tcf_ff) begin
            fsat[i] = '0;
         end
      end
      rsp_in.force_x   = $signed(fsat[0]);
      rsp_in.force_y   = $signed(fsat[1]);
      rsp_in.force_z   = $signed(fsat[2]);
      rsp_in.too_close = tcf_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vt_ff <= 1'b0;
         vf_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         vt_ff <= ss_last.valid;
         vf_ff <= vt_ff;
         vo_ff <= vf_ff;
      end
      tct_ff <= ss_last.too_close;
      ut_ff  <= ss_last.u;
      t_ff   <= t_in;
      tcf_ff <= tct_ff;
      fp_ff  <= fp_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = vo_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire
